>>> hdl/lvfr_pkg.sv
// Shared types and constants of the linear volume fade ramp.
`timescale 1ns / 1ps
`default_nettype none
package lvfr_pkg;

    localparam int NOW_W      = 32;
    localparam int VOL_W      = 16;
    localparam int DUR_W      = 23;
    localparam int INT_W      = 31;
    localparam int FRAC_SHIFT = 8;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 24;
    localparam int CNT_W      = 5;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [VOL_W-1:0] VOL_MAX = 16'hFFFF;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Register index as decoded from the word address bit of paddr.
    localparam logic REG_DEVICE_OPEN = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CMP,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic tready;
        logic div_start;
        logic cmp_start;
        logic commit;
    } ctl_t;

endpackage
`default_nettype wire

>>> hdl/linear_volume_fade_ramp.sv
// Top level of the linear volume fade ramp: control, fade state and ports.
// A start request that needs a division runs through the bit-serial divider and
// a tick during a fade through the bit-serial add and compare; all other requests
// go from idle straight to the wait for the output register.
// One request is in work at a time; the next is accepted once its result is in
// the output register. Reset is synchronous and active low, clears the fade
// state and device_open at once, and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module linear_volume_fade_ramp #(
    parameter int STEP_SIZE = 256
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: now_ms[31:0], start_volume[47:32], target_volume[63:48],
    // duration_ms[86:64], zero[87]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [lvfr_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser: func[0]
    input  wire logic                            s_tuser,
    // m_tdata: status[0], write_valid[1], new_volume[17:2], fade_done[18],
    // fade_active[19], zero[23:20]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [lvfr_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lvfr_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [lvfr_pkg::DATA_W-1:0]     pwdata,
    output logic [lvfr_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import lvfr_pkg::*;

    localparam logic [VOL_W:0]   STEP_UP = (VOL_W + 1)'(STEP_SIZE);
    localparam logic [VOL_W-1:0] STEP_DN = VOL_W'(STEP_SIZE);

    state_t state_reg;
    state_t state_next;
    ctl_t   ctl;

    logic             dev_open_reg;
    logic             active_reg;
    logic             active_next;
    logic             going_up_reg;
    logic             going_up_next;
    logic [VOL_W-1:0] cur_vol_reg;
    logic [VOL_W-1:0] cur_vol_next;
    logic [VOL_W-1:0] goal_vol_reg;
    logic [VOL_W-1:0] goal_vol_next;
    logic [INT_W-1:0] step_int_reg;
    logic [INT_W-1:0] step_int_next;
    logic [NOW_W-1:0] last_step_reg;
    logic [NOW_W-1:0] last_step_next;

    logic             func_reg;
    logic [NOW_W-1:0] now_reg;
    logic [VOL_W-1:0] from_reg;
    logic [VOL_W-1:0] to_reg;

    logic [NOW_W-1:0] in_now;
    logic [VOL_W-1:0] in_from;
    logic [VOL_W-1:0] in_to;
    logic [DUR_W-1:0] in_dur;
    logic             in_up;
    logic [VOL_W-1:0] in_diff;
    logic [INT_W-1:0] in_dividend;
    logic             run_div;
    logic             run_cmp;

    logic             div_done;
    logic [INT_W-1:0] quotient;
    logic             cmp_done;
    logic             due_lt;

    logic [VOL_W:0]   vol_up;
    logic [VOL_W-1:0] vol_stepped;
    logic             res_status;
    logic             res_wv;
    logic             res_done;

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  out_free;
    logic                  cfg_wr;

    // Request fields and the operands the serial units are loaded with.
    always_comb begin
        in_now      = s_tdata[NOW_W-1:0];
        in_from     = s_tdata[NOW_W+VOL_W-1:NOW_W];
        in_to       = s_tdata[NOW_W+2*VOL_W-1:NOW_W+VOL_W];
        in_dur      = s_tdata[NOW_W+2*VOL_W+DUR_W-1:NOW_W+2*VOL_W];
        in_up       = in_to > in_from;
        in_diff     = in_up ? (in_to - in_from) : (in_from - in_to);
        in_dividend = {in_dur, FRAC_SHIFT'(0)};
        run_div     = (s_tuser == FUNC_START) && dev_open_reg && (in_from != in_to);
        run_cmp     = (s_tuser == FUNC_TICK) && active_reg;
    end

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (run_div) begin
                        state_next = ST_DIV;
                    end else if (run_cmp) begin
                        state_next = ST_CMP;
                    end else begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_WAIT;
                end
            end
            ST_CMP: begin
                if (cmp_done) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl = '0;
        case (state_reg)
            ST_IDLE: begin
                ctl.tready    = 1'b1;
                ctl.div_start = s_tvalid && run_div;
                ctl.cmp_start = s_tvalid && run_cmp;
            end
            ST_WAIT: begin
                ctl.commit = out_free;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    assign s_tready = ctl.tready;

    lvfr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.div_start),
        .dividend (in_dividend),
        .divisor  (in_diff),
        .done     (div_done),
        .quotient (quotient)
    );

    lvfr_due u_due (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ctl.cmp_start),
        .last_time (last_step_reg),
        .interval  (step_int_reg),
        .now_time  (in_now),
        .done      (cmp_done),
        .due_lt    (due_lt)
    );

    // Saturating step of the current volume toward the goal.
    always_comb begin
        vol_up = {1'b0, cur_vol_reg} + STEP_UP;
        if (going_up_reg) begin
            vol_stepped = vol_up[VOL_W] ? VOL_MAX : vol_up[VOL_W-1:0];
        end else begin
            vol_stepped = (cur_vol_reg < STEP_DN) ? '0 : (cur_vol_reg - STEP_DN);
        end
    end

    // Result and new fade state of the request held in the capture registers.
    always_comb begin
        active_next    = active_reg;
        going_up_next  = going_up_reg;
        cur_vol_next   = cur_vol_reg;
        goal_vol_next  = goal_vol_reg;
        step_int_next  = step_int_reg;
        last_step_next = last_step_reg;
        res_status     = 1'b0;
        res_wv         = 1'b0;
        res_done       = 1'b0;
        if (func_reg == FUNC_START) begin
            if (dev_open_reg) begin
                res_status    = 1'b1;
                cur_vol_next  = from_reg;
                goal_vol_next = to_reg;
                if (from_reg == to_reg) begin
                    active_next = 1'b0;
                    res_done    = 1'b1;
                end else begin
                    going_up_next  = to_reg > from_reg;
                    step_int_next  = quotient;
                    last_step_next = now_reg;
                    active_next    = 1'b1;
                end
            end
        end else if (active_reg) begin
            if (due_lt) begin
                cur_vol_next   = vol_stepped;
                last_step_next = now_reg;
                res_wv         = 1'b1;
            end
            if (going_up_reg ? (goal_vol_reg <= cur_vol_next)
                             : (goal_vol_reg >= cur_vol_next)) begin
                active_next = 1'b0;
                res_done    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            going_up_reg  <= 1'b0;
            cur_vol_reg   <= '0;
            goal_vol_reg  <= '0;
            step_int_reg  <= '0;
            last_step_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ctl.commit) begin
                active_reg    <= active_next;
                going_up_reg  <= going_up_next;
                cur_vol_reg   <= cur_vol_next;
                goal_vol_reg  <= goal_vol_next;
                step_int_reg  <= step_int_next;
                last_step_reg <= last_step_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && ctl.tready) begin
            func_reg <= s_tuser;
            now_reg  <= in_now;
            from_reg <= in_from;
            to_reg   <= in_to;
        end
        if (ctl.commit) begin
            m_data_reg <= {4'b0000, active_next, res_done, cur_vol_next, res_wv,
                           res_status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Configuration port; byte offset bits of paddr are ignored.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_open_reg <= 1'b0;
        end else if (cfg_wr && (paddr[2] == REG_DEVICE_OPEN)) begin
            dev_open_reg <= pwdata[0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_DEVICE_OPEN) begin
            prdata = DATA_W'(dev_open_reg);
        end else begin
            prdata = '0;
        end
    end

endmodule
`default_nettype wire

>>> hdl/lvfr_div.sv
// Bit-serial restoring divider that produces the fade step interval.
`timescale 1ns / 1ps
`default_nettype none
module lvfr_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [lvfr_pkg::INT_W-1:0] dividend,
    input  wire logic [lvfr_pkg::VOL_W-1:0] divisor,
    output logic                            done,
    output logic [lvfr_pkg::INT_W-1:0]      quotient
);
    import lvfr_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(INT_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [VOL_W-1:0] rem_reg;
    logic [VOL_W-1:0] rem_next;
    logic [INT_W-1:0] q_reg;
    logic [INT_W-1:0] q_next;
    logic [VOL_W-1:0] div_reg;
    logic [VOL_W:0]   rem_sh;
    logic [VOL_W:0]   rem_dif;
    logic             fits;

    // One quotient bit per cycle: dividend bits leave q_reg at the top while
    // quotient bits enter at the bottom.
    always_comb begin
        rem_sh   = {rem_reg, q_reg[INT_W-1]};
        fits     = rem_sh >= {1'b0, div_reg};
        rem_dif  = rem_sh - {1'b0, div_reg};
        rem_next = fits ? rem_dif[VOL_W-1:0] : rem_sh[VOL_W-1:0];
        q_next   = {q_reg[INT_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg   <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

>>> hdl/lvfr_due.sv
// Bit-serial adder and signed comparator that decides whether a step is due.
`timescale 1ns / 1ps
`default_nettype none
module lvfr_due (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [lvfr_pkg::NOW_W-1:0] last_time,
    input  wire logic [lvfr_pkg::INT_W-1:0] interval,
    input  wire logic [lvfr_pkg::NOW_W-1:0] now_time,
    output logic                            done,
    output logic                            due_lt
);
    import lvfr_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NOW_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NOW_W-1:0] a_reg;
    logic [INT_W-1:0] b_reg;
    logic [NOW_W-1:0] c_reg;
    logic             carry_reg;
    logic             lt_reg;
    logic             sum_bit;
    logic             carry_next;
    logic             lt_next;

    // The sum last_time + interval is formed least significant bit first and
    // compared with now_time on the fly. At the sign bit the roles flip, which
    // turns the unsigned compare into a signed one.
    always_comb begin
        sum_bit    = a_reg[0] ^ b_reg[0] ^ carry_reg;
        carry_next = (a_reg[0] & b_reg[0]) | (a_reg[0] & carry_reg)
                   | (b_reg[0] & carry_reg);
        if (cnt_reg == CNT_LAST) begin
            lt_next = (sum_bit & ~c_reg[0]) | (~(sum_bit ^ c_reg[0]) & lt_reg);
        end else begin
            lt_next = (~sum_bit & c_reg[0]) | (~(sum_bit ^ c_reg[0]) & lt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg     <= last_time;
            b_reg     <= interval;
            c_reg     <= now_time;
            carry_reg <= 1'b0;
            lt_reg    <= 1'b0;
        end else if (busy_reg) begin
            a_reg     <= {1'b0, a_reg[NOW_W-1:1]};
            b_reg     <= {1'b0, b_reg[INT_W-1:1]};
            c_reg     <= {1'b0, c_reg[NOW_W-1:1]};
            carry_reg <= carry_next;
            lt_reg    <= lt_next;
        end
    end

    assign done   = done_reg;
    assign due_lt = lt_reg;

endmodule
`default_nettype wire

>>> hdl/lvfr_chk.sv
// Port-level checker of the linear volume fade ramp and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module lvfr_chk (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [lvfr_pkg::OUT_DATA_W-1:0] m_tdata
);
    import lvfr_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Only one request is in work: the block is busy right after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    // A finished fade is never reported as still in progress.
    a_done_vs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[18] && m_tdata[19]))
        else $error("fade both done and active");

    // A start never issues a volume on its own.
    a_start_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("accepted start issued a volume");

endmodule

bind linear_volume_fade_ramp lvfr_chk u_lvfr_chk (.*);
`default_nettype wire
